### src/hta_pkg.sv
// Shared types and constants for the handle table allocator.
// Holds field widths, action, status and state codes, and the search candidate struct.
// Depends on nothing; every other source file imports it.
package hta_pkg;

  // Field widths of the request and result items
  localparam int ACT_W      = 3;
  localparam int KEY_W      = 64;
  localparam int KIND_W     = 2;
  localparam int SLOT_NUM_W = 10;
  localparam int STATUS_W   = 2;
  localparam int RID_W      = 6;
  localparam int KCNT_W     = 7;
  localparam int STAMP_W    = 32;

  // Stream word sizes (padded to whole bytes)
  localparam int IN_TDATA_W  = 80;
  localparam int IN_TUSER_W  = 8;
  localparam int OUT_TDATA_W = 16;

  // Table defaults and kind bookkeeping
  localparam int DEF_TABLE_SLOTS = 64;
  localparam int NUM_KINDS       = 3;
  localparam int KCNT_MAX        = 127;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_FIND   = 3'd2,
    ACT_GET    = 3'd3,
    ACT_CHANGE = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK   = 2'd0,
    STS_MISS = 2'd1,
    STS_BAD  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACCESS,
    S_SEARCH,
    S_PUSH
  } state_t;

  // One entry presented to the best-match tracker per cycle
  typedef struct packed {
    logic               clear;
    logic               en;
    logic               hit;
    logic [STAMP_W-1:0] age;
  } hta_cand_t;

endpackage

### src/hta_search.sv
// Best-match tracker for the find scan of the handle table allocator.
// Keeps the youngest matching slot seen so far; ties keep the lower id.
// Depends on hta_pkg.
module hta_search
  import hta_pkg::*;
#(
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  hta_cand_t        cand,
  input  logic [IDX_W-1:0] cand_id,
  output logic             found_nxt,
  output logic [IDX_W-1:0] best_id_nxt
);

  logic               found_r;
  logic [STAMP_W-1:0] best_age_r;
  logic [STAMP_W-1:0] best_age_nxt;
  logic [IDX_W-1:0]   best_id_r;
  logic               base_found;
  logic               take;

  // Replace the held best only by a strictly younger match
  always_comb begin
    base_found   = cand.clear ? 1'b0 : found_r;
    take         = cand.en && cand.hit && (!base_found || (cand.age < best_age_r));
    found_nxt    = base_found || take;
    best_id_nxt  = take ? cand_id : best_id_r;
    best_age_nxt = take ? cand.age : best_age_r;
  end

  // Hold the found flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cand.clear || cand.en) begin
      found_r <= found_nxt;
    end
  end

  // Hold the best age and id
  always_ff @(posedge clk) begin
    if (cand.en) begin
      best_age_r <= best_age_nxt;
      best_id_r  <= best_id_nxt;
    end
  end

endmodule

### src/handle_table_allocator_core.sv
// Top level of the handle table allocator: request and result streams, control sequencer,
// live bits, per-kind counts and the slot memory of key, kind and stamp.
// Depends on hta_pkg and hta_search.
//
//  Port group | Direction | Contents
//  in_*       | slave     | tdata: action[2:0], item_key[66:3], slot_number[76:67]; tuser: item_kind
//  out_*      | master    | tdata: status[1:0], result_id[7:2], kind_count[14:8]
//
// One request is handled at a time. Insert walks the live bits one slot a cycle from the
// rotating pointer until it claims a free slot or has tried every slot. Find reads every
// slot memory entry in turn through the one read port. Remove, get and change key read the
// addressed slot once and then act on it; only change key writes the entry back. A rejected
// request (bad or free id, kind 3 insert, undefined action) goes straight to the result.
// Reset is synchronous and clears every slot to free at once through the live bits; no
// clearing pass. A stalled result register holds the finished result, and the next request
// is taken while it waits.
module handle_table_allocator_core
  import hta_pkg::*;
#(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // action, item_key, slot_number, zero pad
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // item_kind, zero pad
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // status, result_id, kind_count, zero pad
);

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam logic [IDX_W-1:0]      IDX_LAST  = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [SLOT_NUM_W:0]   SLOTS_LIM = (SLOT_NUM_W + 1)'(TABLE_SLOTS);
  localparam logic [KCNT_W+CNT_W-1:0] SAT_LIM = (KCNT_W + CNT_W)'(KCNT_MAX);

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [KIND_W-1:0]  kind;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // Request fields
  action_t               in_act;
  logic [KEY_W-1:0]      in_key;
  logic [KIND_W-1:0]     in_kind;
  logic [SLOT_NUM_W-1:0] in_slot;
  logic [IDX_W-1:0]      in_id;
  logic                  in_id_ok;
  logic                  accept;
  logic                  push_ok;

  // Control and state registers
  state_t              state_r, state_nxt;
  action_t             req_act_r, req_act_nxt;
  logic [KEY_W-1:0]    req_key_r, req_key_nxt;
  logic [KIND_W-1:0]   req_kind_r, req_kind_nxt;
  logic [IDX_W-1:0]    req_id_r, req_id_nxt;
  logic [TABLE_SLOTS-1:0] live_r, live_nxt;
  logic [CNT_W-1:0]    kcnt_r [NUM_KINDS];
  logic [CNT_W-1:0]    kcnt_nxt [NUM_KINDS];
  logic [STAMP_W-1:0]  stamp_r, stamp_nxt;
  logic [IDX_W-1:0]    next_slot_r, next_slot_nxt;
  logic [IDX_W-1:0]    ptr_r, ptr_nxt;
  logic [IDX_W-1:0]    ptr_inc;
  logic [IDX_W-1:0]    scan_cnt_r, scan_cnt_nxt;
  logic [IDX_W-1:0]    rd_addr_q_r;
  status_t             res_status_r, res_status_nxt;
  logic [IDX_W-1:0]    res_id_r, res_id_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // Slot memory
  entry_t              slot_mem [TABLE_SLOTS];
  entry_t              rd_data_r;
  logic [IDX_W-1:0]    rd_addr;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  entry_t              mem_wdata;

  // Search tracker and result formatting
  hta_cand_t           cand;
  logic                found_nxt;
  logic [IDX_W-1:0]    best_id_nxt;
  logic [RID_W+IDX_W-1:0]   rid_ext;
  logic [KCNT_W+CNT_W-1:0]  kcnt_ext;
  logic [KCNT_W-1:0]   kind_count;

  // Unpack the request
  assign in_act   = action_t'(in_tdata[ACT_W-1:0]);
  assign in_key   = in_tdata[ACT_W +: KEY_W];
  assign in_slot  = in_tdata[ACT_W + KEY_W +: SLOT_NUM_W];
  assign in_kind  = in_tuser[KIND_W-1:0];
  assign in_id    = in_slot[IDX_W-1:0];
  assign in_id_ok = ({1'b0, in_slot} < SLOTS_LIM) && live_r[in_id];

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign push_ok    = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign ptr_inc    = (ptr_r == IDX_LAST) ? '0 : ptr_r + 1'b1;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_act)
            ACT_INSERT: state_nxt = (in_kind < KIND_W'(NUM_KINDS)) ? S_SCAN : S_PUSH;
            ACT_REMOVE,
            ACT_GET,
            ACT_CHANGE: state_nxt = in_id_ok ? S_ACCESS : S_PUSH;
            ACT_FIND:   state_nxt = S_SEARCH;
            default:    state_nxt = S_PUSH;
          endcase
        end
      end
      S_SCAN: begin
        if (!live_r[ptr_r] || (scan_cnt_r == IDX_LAST)) begin
          state_nxt = S_PUSH;
        end
      end
      S_ACCESS: state_nxt = S_PUSH;
      S_SEARCH: begin
        if (rd_addr_q_r == IDX_LAST) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (push_ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Saturated count of the request's kind and truncated result id
  always_comb begin
    kcnt_ext = '0;
    if (req_kind_r < KIND_W'(NUM_KINDS)) begin
      kcnt_ext = {{KCNT_W{1'b0}}, kcnt_r[req_kind_r]};
    end
    kind_count = (kcnt_ext > SAT_LIM) ? KCNT_W'(KCNT_MAX) : kcnt_ext[KCNT_W-1:0];
    rid_ext    = {{RID_W{1'b0}}, res_id_r};
  end

  // Present the entry read last cycle to the best-match tracker
  always_comb begin
    cand = '{clear: 1'b0, en: 1'b0, hit: 1'b0, age: '0};
    case (state_r)
      S_IDLE: cand.clear = 1'b1;
      S_SEARCH: begin
        cand.en  = 1'b1;
        cand.hit = live_r[rd_addr_q_r] && (rd_data_r.key == req_key_r)
                   && (rd_data_r.kind == req_kind_r);
        cand.age = stamp_r - rd_data_r.stamp;
      end
      default: ;
    endcase
  end

  // Datapath and table updates per state
  always_comb begin
    req_act_nxt    = req_act_r;
    req_key_nxt    = req_key_r;
    req_kind_nxt   = req_kind_r;
    req_id_nxt     = req_id_r;
    live_nxt       = live_r;
    kcnt_nxt       = kcnt_r;
    stamp_nxt      = stamp_r;
    next_slot_nxt  = next_slot_r;
    ptr_nxt        = ptr_r;
    scan_cnt_nxt   = scan_cnt_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    rd_addr        = rd_addr_q_r;
    mem_we         = 1'b0;
    mem_waddr      = ptr_r;
    mem_wdata      = '{key: req_key_r, kind: req_kind_r, stamp: stamp_r};

    case (state_r)
      S_IDLE: begin
        // Latch the request and start the read that it needs
        rd_addr    = (in_act == ACT_FIND) ? '0 : in_id;
        if (accept) begin
          req_act_nxt    = in_act;
          req_key_nxt    = in_key;
          req_kind_nxt   = in_kind;
          req_id_nxt     = in_id;
          ptr_nxt        = next_slot_r;
          scan_cnt_nxt   = '0;
          res_status_nxt = (in_act == ACT_INSERT) ? STS_MISS : STS_BAD;
          res_id_nxt     = '0;
        end
      end
      S_SCAN: begin
        // Claim the first free slot or advance the pointer
        if (!live_r[ptr_r]) begin
          mem_we           = 1'b1;
          mem_waddr        = ptr_r;
          live_nxt[ptr_r]  = 1'b1;
          if (req_kind_r < KIND_W'(NUM_KINDS)) begin
            kcnt_nxt[req_kind_r] = kcnt_r[req_kind_r] + 1'b1;
          end
          next_slot_nxt  = ptr_inc;
          stamp_nxt      = stamp_r + 1'b1;
          res_status_nxt = STS_OK;
          res_id_nxt     = ptr_r;
        end else if (scan_cnt_r != IDX_LAST) begin
          ptr_nxt      = ptr_inc;
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
      end
      S_ACCESS: begin
        // Act on the addressed slot that was read; only change key writes it back
        case (req_act_r)
          ACT_REMOVE: begin
            live_nxt[req_id_r] = 1'b0;
            if ((rd_data_r.kind < KIND_W'(NUM_KINDS)) && (kcnt_r[rd_data_r.kind] != '0)) begin
              kcnt_nxt[rd_data_r.kind] = kcnt_r[rd_data_r.kind] - 1'b1;
            end
            res_status_nxt = STS_OK;
            res_id_nxt     = req_id_r;
          end
          ACT_GET: begin
            if (rd_data_r.kind == req_kind_r) begin
              res_status_nxt = STS_OK;
              res_id_nxt     = req_id_r;
            end
          end
          ACT_CHANGE: begin
            mem_we         = 1'b1;
            mem_waddr      = req_id_r;
            mem_wdata      = '{key: req_key_r, kind: rd_data_r.kind, stamp: stamp_r};
            stamp_nxt      = stamp_r + 1'b1;
            res_status_nxt = STS_OK;
            res_id_nxt     = req_id_r;
          end
          default: res_status_nxt = STS_BAD;
        endcase
      end
      S_SEARCH: begin
        // Compare the entry read last cycle, fetch the next one
        rd_addr   = (rd_addr_q_r == IDX_LAST) ? '0 : rd_addr_q_r + 1'b1;
        if (rd_addr_q_r == IDX_LAST) begin
          res_status_nxt = found_nxt ? STS_OK : STS_MISS;
          res_id_nxt     = found_nxt ? best_id_nxt : '0;
        end
      end
      S_PUSH: begin
        // Load the result register once it is free
        if (push_ok) begin
          out_valid_nxt = 1'b1;
          out_tdata_nxt = {1'b0, kind_count, rid_ext[RID_W-1:0], res_status_r};
        end
      end
      default: ;
    endcase
  end

  hta_search #(
    .IDX_W (IDX_W)
  ) u_search (
    .clk         (clk),
    .rst_n       (rst_n),
    .cand        (cand),
    .cand_id     (rd_addr_q_r),
    .found_nxt   (found_nxt),
    .best_id_nxt (best_id_nxt)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      kcnt_r      <= '{default: '0};
      stamp_r     <= '0;
      next_slot_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      kcnt_r      <= kcnt_nxt;
      stamp_r     <= stamp_nxt;
      next_slot_r <= next_slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    req_act_r    <= req_act_nxt;
    req_key_r    <= req_key_nxt;
    req_kind_r   <= req_kind_nxt;
    req_id_r     <= req_id_nxt;
    ptr_r        <= ptr_nxt;
    scan_cnt_r   <= scan_cnt_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    out_tdata_r  <= out_tdata_nxt;
    rd_addr_q_r  <= rd_addr;
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= slot_mem[rd_addr];
  end

  // Only one request is in flight
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("request taken while another is in flight");

  // Per-kind counts agree with the live bits
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(kcnt_r[0]) + int'(kcnt_r[1]) + int'(kcnt_r[2])) == $countones(live_r))
    else $error("kind counts disagree with live slots");

  // A failed request reports id zero
  a_fail_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_tdata_r[STATUS_W-1:0] != STS_OK))
      |-> (out_tdata_r[STATUS_W +: RID_W] == '0))
    else $error("failed result carries a nonzero id");

  // The rotating pointer stays inside the table
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    next_slot_r <= IDX_LAST)
    else $error("insert pointer beyond the table");

  // A result is loaded only on leaving the push state
  a_push_leave: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH && push_ok) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not loaded when leaving push");

endmodule

### test/handle_table_allocator_core_tb.sv
// Self-checking testbench for handle_table_allocator_core: drives insert, remove, find, get and
// change-key requests over the input stream and checks every result against a slot-table tracker.
// Depends on hta_pkg and the handle_table_allocator_core RTL.
module handle_table_allocator_core_tb;
  import hta_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = DEF_TABLE_SLOTS;
  localparam int N_RANDOM    = 450;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  // Modes of the random part
  localparam int MODE_FILL  = 0;
  localparam int MODE_MIXED = 1;
  localparam int MODE_DRAIN = 2;

  typedef struct packed {
    logic [ACT_W-1:0]      action;
    logic [KEY_W-1:0]      key;
    logic [KIND_W-1:0]     kind;
    logic [SLOT_NUM_W-1:0] slot_num;
  } request_t;

  typedef struct packed {
    status_t           status;
    logic [RID_W-1:0]  rid;
    logic [KCNT_W-1:0] kcnt;
  } outcome_t;

  // Tracks the slot table request by request and holds the outcomes still to arrive
  class handle_table_tracker;
    bit                live_mark [SLOTS];
    logic [KEY_W-1:0]  held_key [SLOTS];
    logic [KIND_W-1:0] held_kind [SLOTS];
    bit [STAMP_W-1:0]  held_stamp [SLOTS];
    bit [STAMP_W-1:0]  stamp_count;
    int unsigned       rr_next;
    int unsigned       kind_live [NUM_KINDS];
    outcome_t          outcome_q [$];
    int                failures;
    int                seen;

    function new();
      foreach (live_mark[i]) live_mark[i] = 1'b0;
      foreach (kind_live[i]) kind_live[i] = 0;
      stamp_count = '0;
      rr_next = 0;
      failures = 0;
      seen = 0;
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction

    // Apply one accepted request to the table and queue the outcome it must give
    function void note_request(request_t r);
      outcome_t         o;
      int unsigned      id;
      int unsigned      p;
      int unsigned      k;
      bit               id_ok;
      bit               found;
      bit [STAMP_W-1:0] age;
      bit [STAMP_W-1:0] best_age;
      o.status = STS_BAD;
      o.rid = '0;
      id = r.slot_num;
      id_ok = 1'b0;
      if (id < SLOTS) id_ok = live_mark[id];
      found = 1'b0;
      best_age = '0;
      case (r.action)
        ACT_INSERT: begin
          o.status = STS_MISS;
          if (r.kind < NUM_KINDS) begin
            // claim the first free slot from the rotating pointer
            p = rr_next;
            for (int i = 0; i < SLOTS; i++) begin
              if (!found && !live_mark[p]) begin
                found = 1'b1;
                live_mark[p] = 1'b1;
                held_key[p] = r.key;
                held_kind[p] = r.kind;
                held_stamp[p] = stamp_count;
                stamp_count = stamp_count + 1;
                kind_live[r.kind]++;
                rr_next = (p + 1) % SLOTS;
                o.status = STS_OK;
                o.rid = RID_W'(p);
              end
              p = (p + 1) % SLOTS;
            end
          end
        end
        ACT_REMOVE: begin
          if (id_ok) begin
            k = held_kind[id];
            live_mark[id] = 1'b0;
            if (k < NUM_KINDS && kind_live[k] > 0) kind_live[k]--;
            o.status = STS_OK;
            o.rid = RID_W'(id);
          end
        end
        ACT_FIND: begin
          // newest live match wins; ties go to the lowest id
          o.status = STS_MISS;
          for (int i = 0; i < SLOTS; i++) begin
            if (live_mark[i] && held_key[i] == r.key && held_kind[i] == r.kind) begin
              age = stamp_count - held_stamp[i];
              if (!found || age < best_age) begin
                found = 1'b1;
                best_age = age;
                o.rid = RID_W'(i);
              end
            end
          end
          if (found) o.status = STS_OK;
        end
        ACT_GET: begin
          if (id_ok && held_kind[id] == r.kind) begin
            o.status = STS_OK;
            o.rid = RID_W'(id);
          end
        end
        ACT_CHANGE: begin
          if (id_ok) begin
            held_key[id] = r.key;
            held_stamp[id] = stamp_count;
            stamp_count = stamp_count + 1;
            o.status = STS_OK;
            o.rid = RID_W'(id);
          end
        end
        default: o.status = STS_BAD;
      endcase
      if (o.status != STS_OK) o.rid = '0;
      if (r.kind < NUM_KINDS)
        o.kcnt = KCNT_W'((kind_live[r.kind] > KCNT_MAX) ? KCNT_MAX : kind_live[r.kind]);
      else o.kcnt = '0;
      outcome_q.push_back(o);
    endfunction

    // Compare one accepted result with the oldest outstanding outcome
    function void check_outcome(logic [STATUS_W-1:0] st, logic [RID_W-1:0] rid,
                                logic [KCNT_W-1:0] kc);
      outcome_t want;
      seen++;
      if (outcome_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("result %0d arrived with nothing outstanding: status %0d id %0d count %0d",
                   seen, st, rid, kc);
        return;
      end
      want = outcome_q.pop_front();
      if (want.status !== st || want.rid !== rid || want.kcnt !== kc) begin
        failures++;
        if (failures <= 10)
          $display("result %0d: expected status %0d id %0d count %0d, got status %0d id %0d count %0d",
                   seen, want.status, want.rid, want.kcnt, st, rid, kc);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  handle_table_tracker sb = new();
  logic [KEY_W-1:0]    key_pool [8];
  int                  quiet_cycles = 0;

  handle_table_allocator_core #(
    .TABLE_SLOTS(SLOTS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_outcome(out_tdata[1:0], out_tdata[7:2], out_tdata[14:8]);
  end

  // End the run when nothing moves on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Result side: random stalls, one long hold-off, and a calm stretch
  initial begin : rx_side
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sb.seen >= 60) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (sb.seen >= 180 && sb.seen < 300) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(99) >= 8);
    end
  end

  // Offer one request, with an optional random gap, and hold it until taken
  task automatic send_request(input request_t r, input bit may_idle);
    if (may_idle && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 30);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, r.slot_num, r.key, r.action};
    in_tuser  <= {6'b000000, r.kind};
    do @(posedge clk); while (!in_tready);
    sb.note_request(r);
  endtask

  task automatic send_op(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                         input logic [KIND_W-1:0] kind, input logic [SLOT_NUM_W-1:0] slot);
    request_t r;
    r.action = act;
    r.key = key;
    r.kind = kind;
    r.slot_num = slot;
    send_request(r, 1'b1);
  endtask

  // Mostly a live slot, sometimes any slot or an id beyond the table
  function automatic logic [SLOT_NUM_W-1:0] pick_slot();
    int roll;
    int start;
    roll = $urandom_range(99);
    if (roll < 10) return SLOT_NUM_W'($urandom_range(1023));
    if (roll < 25) return SLOT_NUM_W'($urandom_range(SLOTS - 1));
    start = $urandom_range(SLOTS - 1);
    for (int i = 0; i < SLOTS; i++)
      if (sb.live_mark[(start + i) % SLOTS]) return SLOT_NUM_W'((start + i) % SLOTS);
    return SLOT_NUM_W'(start);
  endfunction

  function automatic request_t random_request(input int mode);
    request_t r;
    int       roll;
    int       ins_share;
    int       rem_share;
    roll = $urandom_range(99);
    r.key = ($urandom_range(3) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(7)];
    r.kind = ($urandom_range(15) == 0) ? 2'd3 : KIND_W'($urandom_range(NUM_KINDS - 1));
    r.slot_num = pick_slot();
    case (mode)
      MODE_FILL:  begin ins_share = 85; rem_share = 3;  end
      MODE_DRAIN: begin ins_share = 5;  rem_share = 60; end
      default:    begin ins_share = 25; rem_share = 20; end
    endcase
    if (roll < ins_share) begin
      r.action = ACT_INSERT;
    end else if (roll < ins_share + rem_share) begin
      r.action = ACT_REMOVE;
    end else if (roll >= 97) begin
      r.action = ACT_W'($urandom_range(5, 7));
    end else begin
      case ($urandom_range(2))
        0:       r.action = ACT_FIND;
        1:       r.action = ACT_GET;
        default: r.action = ACT_CHANGE;
      endcase
    end
    // for half of the finds and gets on a live slot, borrow its kind, and for finds its key too
    if (r.slot_num < SLOTS && sb.live_mark[r.slot_num] && $urandom_range(1) == 1) begin
      if (r.action == ACT_FIND) r.key = sb.held_key[r.slot_num];
      if (r.action == ACT_FIND || r.action == ACT_GET) r.kind = sb.held_kind[r.slot_num];
    end
    return r;
  endfunction

  initial begin : stimulus
    request_t r;
    int       mode;
    localparam logic [KEY_W-1:0] ONES = '1;
    mode = MODE_FILL;
    key_pool[0] = '0;
    key_pool[1] = ONES;
    for (int i = 2; i < 8; i++) key_pool[i] = {$urandom, $urandom};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every action and the documented corner cases
    send_op(ACT_INSERT, '0,   2'd0, 10'd0);
    send_op(ACT_INSERT, ONES, 2'd1, 10'd1023);
    send_op(ACT_INSERT, ONES, 2'd2, 10'd0);
    send_op(ACT_INSERT, ONES, 2'd2, 10'd0);
    send_op(ACT_INSERT, ONES, 2'd3, 10'd0);     // kind 3 insert is refused
    send_op(ACT_FIND,   ONES, 2'd2, 10'd0);     // newest duplicate wins
    send_op(ACT_FIND,   ONES, 2'd3, 10'd0);     // kind 3 never matches
    send_op(ACT_FIND,   '0,   2'd1, 10'd0);
    send_op(ACT_GET,    '0,   2'd1, 10'd1);
    send_op(ACT_GET,    '0,   2'd0, 10'd1);     // kind mismatch
    send_op(ACT_GET,    '0,   2'd0, 10'd63);    // free slot
    send_op(ACT_GET,    ONES, 2'd1, 10'd1023);  // id beyond the table
    send_op(ACT_REMOVE, '0,   2'd0, 10'd64);
    send_op(ACT_CHANGE, ONES, 2'd0, 10'd2);     // same key, now the newest
    send_op(ACT_FIND,   ONES, 2'd2, 10'd2);
    send_op(ACT_REMOVE, '0,   2'd1, 10'd2);
    send_op(ACT_FIND,   ONES, 2'd2, 10'd0);
    send_op(ACT_REMOVE, '0,   2'd2, 10'd2);     // already free
    send_op(ACT_CHANGE, '0,   2'd0, 10'd1023);
    send_op(ACT_CHANGE, '0,   2'd0, 10'd5);
    send_op(3'd5,       ONES, 2'd0, 10'd0);
    send_op(3'd6,       '0,   2'd1, 10'd1);
    send_op(3'd7,       ONES, 2'd3, 10'd1023);
    send_op(ACT_INSERT, {32'h5555_5555, 32'haaaa_aaaa}, 2'd0, 10'd0);
    send_op(ACT_REMOVE, '0,   2'd3, 10'd0);     // kind ignored on remove
    send_op(ACT_FIND,   '0,   2'd0, 10'd0);

    // Random: bursts of filling, mixed and draining traffic
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 40 == 0) mode = (n < 80) ? MODE_FILL : $urandom_range(2);
      if (n == 380) begin
        // pause until the pipe is empty
        in_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        @(posedge clk);
      end
      r = random_request(mode);
      send_request(r, !(n >= 200 && n < 320));
    end
    in_tvalid <= 1'b0;

    // Drain and let the block settle
    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### handle_table_allocator_core.f
src/hta_pkg.sv
src/hta_search.sv
src/handle_table_allocator_core.sv
test/handle_table_allocator_core_tb.sv
